// File: hw/rtl/jra_pkg.sv
// Shared types, codes and widths for the job resource admission block.
package jra_pkg;

  // Field widths fixed by the interface
  localparam int CPU_W    = 8;
  localparam int GPU_W    = 6;
  localparam int MEM_W    = 32;
  localparam int JTAG_W   = 16;
  localparam int ACT_W    = 5;
  localparam int DONE_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 88;

  // Parameter defaults
  localparam int MAX_JOBS_DEF = 16;
  localparam int TAG_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CPUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_GPUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MEM  = 2'd2;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_RES     = 2'd1,
    STATUS_NOT_ACTIVE = 2'd2,
    STATUS_FULL       = 2'd3
  } status_t;

  // Operation broadcast to every tag cell
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_COMPACT = 2'd3
  } cell_op_t;

  // Per-cell status seen by the controller and the neighbors
  typedef struct packed {
    logic valid;
    logic hit;
    logic hole;
  } cell_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_EVAL    = 2'd1,
    ST_COMPACT = 2'd2
  } state_t;

endpackage

// File: hw/rtl/jra_cell.sv
// One cell of the active tag chain: holds one tag, shifts and compacts with neighbors.
module jra_cell import jra_pkg::*; #(
  parameter int TAG_W = TAG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_op_t         op,
  input  logic [TAG_W-1:0] query,
  input  logic             lo_valid,
  input  logic [TAG_W-1:0] lo_tag,
  input  logic             up_valid,
  input  logic [TAG_W-1:0] up_tag,
  output logic [TAG_W-1:0] tag_o,
  output cell_stat_t       stat_o
);

  logic             valid_r, valid_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic             hit;

  assign hit = valid_r && (tag_r == query);

  // Entry update per broadcast operation
  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    unique case (op)
      OP_HOLD: begin
      end
      // whole chain shifts up by one, new tag enters at the bottom
      OP_INSERT: begin
        valid_nxt = lo_valid;
        tag_nxt   = lo_tag;
      end
      OP_REMOVE: begin
        if (hit) valid_nxt = 1'b0;
      end
      // an empty cell pulls from above; an entry over a hole moves down
      OP_COMPACT: begin
        if (!valid_r) begin
          valid_nxt = up_valid;
          tag_nxt   = up_tag;
        end else if (!lo_valid) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign tag_o       = tag_r;
  assign stat_o.valid = valid_r;
  assign stat_o.hit   = hit;
  assign stat_o.hole  = !valid_r && up_valid;

endmodule

// File: hw/rtl/job_resource_admission.sv
// An accepted transaction is captured; ST_EVAL loads its result once the output register is free
// (out_tvalid high after). A start or a rejected transaction then returns to ST_IDLE; a completion
// that frees an entry enters ST_COMPACT while the chain closes the freed slot, one cell per cycle.
// A waiting result does not block the next input; its evaluation waits for the output register.
// Reset (synchronous, active low) clears all totals, counts, the busy flag and the tag cells' valid bits.
module job_resource_admission import jra_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] job_tag, [23:16] need_cpus, [29:24] need_gpus, [61:30] need_mem, [63:62] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                  in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [2] busy_res, [7:3] active_count, [15:8] free_cpus, [21:16] free_gpus,
  // [53:22] free_mem, [85:54] completed_total, [87:86] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  // ---------------- state ----------------
  state_t state_r, state_nxt;

  logic              kind_r;
  logic [TAG_BITS-1:0] query_r;
  logic [CPU_W-1:0]  need_cpus_r;
  logic [GPU_W-1:0]  need_gpus_r;
  logic [MEM_W-1:0]  need_mem_r;

  logic [CPU_W-1:0]  total_cpus_r;
  logic [GPU_W-1:0]  total_gpus_r;
  logic [MEM_W-1:0]  total_mem_r;
  logic [CPU_W-1:0]  avail_cpus_r, avail_cpus_nxt;
  logic [GPU_W-1:0]  avail_gpus_r, avail_gpus_nxt;
  logic [MEM_W-1:0]  avail_mem_r,  avail_mem_nxt;
  logic              busy_r, busy_nxt;
  logic [DONE_W-1:0] done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  status_t  status;
  cell_op_t eval_op;
  cell_op_t cell_op;
  logic     in_fire;
  logic     go;
  logic     found;
  logic     fits;
  logic     settled;

  // ---------------- tag chain ----------------
  cell_stat_t          cell_stat [MAX_JOBS];
  logic [TAG_BITS-1:0] cell_tag  [MAX_JOBS];
  logic [MAX_JOBS-1:0] valid_vec, hit_vec, hole_vec;

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    logic                lo_v, up_v;
    logic [TAG_BITS-1:0] lo_t, up_t;

    if (i == 0) begin : g_bottom
      assign lo_v = 1'b1;
      assign lo_t = query_r;
    end else begin : g_lo
      assign lo_v = cell_stat[i-1].valid;
      assign lo_t = cell_tag[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_top
      assign up_v = 1'b0;
      assign up_t = '0;
    end else begin : g_up
      assign up_v = cell_stat[i+1].valid;
      assign up_t = cell_tag[i+1];
    end

    jra_cell #(.TAG_W(TAG_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (cell_op),
      .query    (query_r),
      .lo_valid (lo_v),
      .lo_tag   (lo_t),
      .up_valid (up_v),
      .up_tag   (up_t),
      .tag_o    (cell_tag[i]),
      .stat_o   (cell_stat[i])
    );

    assign valid_vec[i] = cell_stat[i].valid;
    assign hit_vec[i]   = cell_stat[i].hit;
    assign hole_vec[i]  = cell_stat[i].hole;
  end

  assign found   = |hit_vec;
  assign settled = ~|hole_vec;

  // ---------------- handshakes ----------------
  assign in_fire = in_tvalid && in_tready;
  assign go      = (state_r == ST_EVAL) && (!out_valid_r || out_tready);

  // ---------------- admission decision ----------------
  logic [CPU_W:0] sum_cpus;
  logic [GPU_W:0] sum_gpus;
  logic [MEM_W:0] sum_mem;

  assign fits = (avail_cpus_r >= need_cpus_r) && (avail_gpus_r >= need_gpus_r) &&
                (avail_mem_r >= need_mem_r);
  assign sum_cpus = {1'b0, avail_cpus_r} + {1'b0, need_cpus_r};
  assign sum_gpus = {1'b0, avail_gpus_r} + {1'b0, need_gpus_r};
  assign sum_mem  = {1'b0, avail_mem_r}  + {1'b0, need_mem_r};

  always_comb begin
    status         = STATUS_OK;
    eval_op        = OP_HOLD;
    avail_cpus_nxt = avail_cpus_r;
    avail_gpus_nxt = avail_gpus_r;
    avail_mem_nxt  = avail_mem_r;
    busy_nxt       = busy_r;
    done_nxt       = done_r;
    cnt_nxt        = cnt_r;
    if (kind_r == KIND_START) begin
      if (!fits) begin
        status = STATUS_NO_RES;
      end else if (!found && (cnt_r == CNT_W'(MAX_JOBS))) begin
        status = STATUS_FULL;
      end else begin
        // an already active tag is charged again without a new entry
        if (!found) begin
          eval_op = OP_INSERT;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        avail_cpus_nxt = avail_cpus_r - need_cpus_r;
        avail_gpus_nxt = avail_gpus_r - need_gpus_r;
        avail_mem_nxt  = avail_mem_r - need_mem_r;
        busy_nxt       = 1'b1;
      end
    end else begin
      if (!found) begin
        status = STATUS_NOT_ACTIVE;
      end else begin
        eval_op = OP_REMOVE;
        cnt_nxt = cnt_r - CNT_W'(1);
        // returned units saturate at the totals
        avail_cpus_nxt = (sum_cpus < {1'b0, total_cpus_r}) ? sum_cpus[CPU_W-1:0] : total_cpus_r;
        avail_gpus_nxt = (sum_gpus < {1'b0, total_gpus_r}) ? sum_gpus[GPU_W-1:0] : total_gpus_r;
        avail_mem_nxt  = (sum_mem < {1'b0, total_mem_r}) ? sum_mem[MEM_W-1:0] : total_mem_r;
        if (cnt_nxt == '0) busy_nxt = 1'b0;
        done_nxt = done_r + DONE_W'(1);
      end
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_EVAL;
      ST_EVAL:    if (go) state_nxt = (eval_op == OP_REMOVE) ? ST_COMPACT : ST_IDLE;
      ST_COMPACT: if (settled) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cell_op   = OP_HOLD;
    unique case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_EVAL:    if (go) cell_op = eval_op;
      ST_COMPACT: cell_op = OP_COMPACT;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- input capture ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= in_tuser;
      query_r     <= TAG_BITS'(in_tdata[15:0]);
      need_cpus_r <= in_tdata[23:16];
      need_gpus_r <= in_tdata[29:24];
      need_mem_r  <= in_tdata[61:30];
    end
  end

  // ---------------- resource state and configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_cpus_r <= '0;
      total_gpus_r <= '0;
      total_mem_r  <= '0;
      avail_cpus_r <= '0;
      avail_gpus_r <= '0;
      avail_mem_r  <= '0;
      busy_r       <= 1'b0;
      done_r       <= '0;
      cnt_r        <= '0;
    end else begin
      if (go) begin
        avail_cpus_r <= avail_cpus_nxt;
        avail_gpus_r <= avail_gpus_nxt;
        avail_mem_r  <= avail_mem_nxt;
        busy_r       <= busy_nxt;
        done_r       <= done_nxt;
        cnt_r        <= cnt_nxt;
      end
      // a total write also resets the matching available count
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL_CPUS) begin
          total_cpus_r <= cfg_wdata[CPU_W-1:0];
          avail_cpus_r <= cfg_wdata[CPU_W-1:0];
        end
        if (cfg_index == REG_TOTAL_GPUS) begin
          total_gpus_r <= cfg_wdata[GPU_W-1:0];
          avail_gpus_r <= cfg_wdata[GPU_W-1:0];
        end
        if (cfg_index == REG_TOTAL_MEM) begin
          total_mem_r <= cfg_wdata[MEM_W-1:0];
          avail_mem_r <= cfg_wdata[MEM_W-1:0];
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= {2'b00, done_nxt, avail_mem_nxt, avail_gpus_nxt, avail_cpus_nxt,
                     ACT_W'(cnt_nxt), busy_nxt, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // fill count tracks the cells that hold a tag
  a_cnt_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(cnt_r))
    else $error("active count differs from valid cells");

  // busy exactly while some job is active
  a_busy_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (cnt_r != '0))
    else $error("busy flag out of step with active count");

  // the chain is gap-free whenever a new transaction can enter
  a_idle_compacted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> settled)
    else $error("tag chain has a hole while idle");

  // returned units never push a count past its total
  a_avail_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (avail_cpus_r <= total_cpus_r) && (avail_gpus_r <= total_gpus_r) &&
    (avail_mem_r <= total_mem_r))
    else $error("available count above total");

  // a tag is never held by two cells
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("duplicate tag in chain");
`endif

endmodule
